// ===== rtl/pcls_pkg.sv =====
// Shared constants for the point centroid and sort block.
package pcls_pkg;

  // Width of the result coordinate ports.
  localparam int OUT_W = 24;

  // Fraction bits of the centroid result.
  localparam int FRAC_BITS = 8;

  // Result kind codes.
  localparam logic KIND_CENTROID = 1'b0;
  localparam logic KIND_POINT    = 1'b1;

endpackage

// ===== rtl/point_centroid_and_lex_sort.sv =====
// Point set loader with centroid divider and in-place insertion sort.
// Load: one point per cycle, start taken whenever busy is low.
// After the last point, the shared restoring divider handles x and then y on an NW-bit
// numerator (NW = COORD_BITS + clog2(MAX_POINTS+1) + 8); the centroid word follows.
// Sorting inserts each point in turn, shifting larger neighbors up; then the points are emitted.
// The two-port point memory sets the sort and emit pace; results cannot be stalled.
// rst_n is synchronous; it clears the sequencer, the count, the sums and the strobe.
module point_centroid_and_lex_sort
  import pcls_pkg::*;
#(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic                         in_last_point,
  output logic                         out_valid,
  output logic                         out_result_kind,
  output logic signed [OUT_W-1:0]      out_x,
  output logic signed [OUT_W-1:0]      out_y,
  output logic                         out_last_result
);

  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int IW  = $clog2(MAX_POINTS);
  localparam int SW  = COORD_BITS + CW;
  localparam int NW  = SW + FRAC_BITS;
  localparam int SCW = $clog2(NW + 1);
  localparam int MW  = 2 * COORD_BITS;
  localparam int EXW = COORD_BITS + OUT_W;

  typedef enum logic [3:0] {
    S_LOAD,
    S_DIV_LD,
    S_DIV,
    S_DIV_END,
    S_CENT,
    S_SORT_INIT,
    S_KEY,
    S_CMP,
    S_PLACE,
    S_EMIT_RD,
    S_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic signed [SW-1:0]  sum_x_r, sum_x_nxt;
  logic signed [SW-1:0]  sum_y_r, sum_y_nxt;
  logic                  div_y_r, div_y_nxt;
  logic [NW-1:0]         num_r, num_nxt;
  logic [CW-1:0]         rem_r, rem_nxt;
  logic [OUT_W-1:0]      q_r, q_nxt;
  logic                  neg_r, neg_nxt;
  logic [SCW-1:0]        step_r, step_nxt;
  logic [OUT_W-1:0]      cx_r, cx_nxt;
  logic [OUT_W-1:0]      cy_r, cy_nxt;
  logic [MW-1:0]         key_r, key_nxt;
  logic [IW-1:0]         i_r, i_nxt;
  logic [IW-1:0]         j_r, j_nxt;
  logic [IW-1:0]         k_r, k_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_kind_r, out_kind_nxt;
  logic [OUT_W-1:0]      out_x_r, out_x_nxt;
  logic [OUT_W-1:0]      out_y_r, out_y_nxt;
  logic                  out_last_r, out_last_nxt;

  // Point memory: one write and one registered read per cycle.
  logic [MW-1:0]         mem [MAX_POINTS];
  logic [MW-1:0]         rd_data_r;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [MW-1:0]         wr_data;
  logic [IW-1:0]         rd_addr;

  logic signed [COORD_BITS-1:0] rd_x, rd_y, key_x, key_y;
  logic                  rd_gt_key;
  logic signed [EXW-1:0] ext_x, ext_y;
  logic signed [SW-1:0]  sum_sel;
  logic [SW-1:0]         mag;
  logic [CW:0]           shifted;
  logic [CW+1:0]         trial;
  logic                  borrow;
  logic [OUT_W-1:0]      quot_signed;
  logic                  accept;
  logic                  i_done;
  logic                  k_done;

  assign accept = start && (state_r == S_LOAD);

  assign rd_x  = rd_data_r[MW-1:COORD_BITS];
  assign rd_y  = rd_data_r[COORD_BITS-1:0];
  assign key_x = key_r[MW-1:COORD_BITS];
  assign key_y = key_r[COORD_BITS-1:0];

  // Comparator: x first, y breaks ties.
  assign rd_gt_key = (rd_x > key_x) || ((rd_x == key_x) && (rd_y > key_y));

  assign ext_x = EXW'(rd_x);
  assign ext_y = EXW'(rd_y);

  // Divider datapath: one restoring step per cycle on the magnitude.
  assign sum_sel = div_y_r ? sum_y_r : sum_x_r;
  assign mag     = sum_sel[SW-1] ? (~sum_sel + SW'(1)) : sum_sel;
  assign shifted = {rem_r, num_r[NW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, cnt_r};
  assign borrow  = trial[CW+1];
  // Truncation toward zero: negate the magnitude quotient, modulo the port width.
  assign quot_signed = neg_r ? (~q_r + OUT_W'(1)) : q_r;

  assign i_done = (CW'(i_r) + CW'(1)) == cnt_r;
  assign k_done = (CW'(k_r) + CW'(1)) == cnt_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    div_y_nxt     = div_y_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    key_nxt       = key_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = j_r;
    wr_data       = key_r;
    rd_addr       = '0;

    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          // A point beyond capacity is dropped, but a last flag still closes the set.
          if (cnt_r < CW'(MAX_POINTS)) begin
            wr_en     = 1'b1;
            wr_addr   = cnt_r[IW-1:0];
            wr_data   = {in_point_x, in_point_y};
            cnt_nxt   = cnt_r + CW'(1);
            sum_x_nxt = sum_x_r + SW'(in_point_x);
            sum_y_nxt = sum_y_r + SW'(in_point_y);
          end
          if (in_last_point) begin
            div_y_nxt = 1'b0;
            state_nxt = S_DIV_LD;
          end
        end
      end

      S_DIV_LD: begin
        num_nxt   = {mag, {FRAC_BITS{1'b0}}};
        neg_nxt   = sum_sel[SW-1];
        rem_nxt   = '0;
        q_nxt     = '0;
        step_nxt  = SCW'(NW);
        state_nxt = S_DIV;
      end

      S_DIV: begin
        num_nxt  = {num_r[NW-2:0], 1'b0};
        rem_nxt  = borrow ? shifted[CW-1:0] : trial[CW-1:0];
        q_nxt    = {q_r[OUT_W-2:0], ~borrow};
        step_nxt = step_r - SCW'(1);
        if (step_r == SCW'(1)) begin
          state_nxt = S_DIV_END;
        end
      end

      S_DIV_END: begin
        if (div_y_r) begin
          cy_nxt    = quot_signed;
          state_nxt = S_CENT;
        end else begin
          cx_nxt    = quot_signed;
          div_y_nxt = 1'b1;
          state_nxt = S_DIV_LD;
        end
      end

      S_CENT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_CENTROID;
        out_x_nxt     = cx_r;
        out_y_nxt     = cy_r;
        out_last_nxt  = 1'b0;
        state_nxt     = S_SORT_INIT;
      end

      S_SORT_INIT: begin
        if (cnt_r <= CW'(1)) begin
          state_nxt = S_EMIT_RD;
        end else begin
          i_nxt     = IW'(1);
          rd_addr   = IW'(1);
          state_nxt = S_KEY;
        end
      end

      S_KEY: begin
        key_nxt   = rd_data_r;
        j_nxt     = i_r;
        rd_addr   = i_r - IW'(1);
        state_nxt = S_CMP;
      end

      S_CMP: begin
        wr_en = 1'b1;
        if (rd_gt_key) begin
          // Shift the larger neighbor up one slot and keep walking down.
          wr_data = rd_data_r;
          j_nxt   = j_r - IW'(1);
          if (j_r == IW'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            rd_addr = j_r - IW'(2);
          end
        end else begin
          wr_data = key_r;
          if (i_done) begin
            state_nxt = S_EMIT_RD;
          end else begin
            i_nxt     = i_r + IW'(1);
            rd_addr   = i_r + IW'(1);
            state_nxt = S_KEY;
          end
        end
      end

      S_PLACE: begin
        wr_en   = 1'b1;
        wr_data = key_r;
        if (i_done) begin
          state_nxt = S_EMIT_RD;
        end else begin
          i_nxt     = i_r + IW'(1);
          rd_addr   = i_r + IW'(1);
          state_nxt = S_KEY;
        end
      end

      S_EMIT_RD: begin
        k_nxt     = '0;
        rd_addr   = '0;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_POINT;
        out_x_nxt     = ext_x[OUT_W-1:0];
        out_y_nxt     = ext_y[OUT_W-1:0];
        out_last_nxt  = k_done;
        if (k_done) begin
          cnt_nxt   = '0;
          sum_x_nxt = '0;
          sum_y_nxt = '0;
          state_nxt = S_LOAD;
        end else begin
          k_nxt   = k_r + IW'(1);
          rd_addr = k_r + IW'(1);
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      div_y_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      div_y_r     <= div_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    neg_r      <= neg_nxt;
    step_r     <= step_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    key_r      <= key_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    out_kind_r <= out_kind_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign busy            = (state_r != S_LOAD);
  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_last_result = out_last_r;

endmodule

// ===== rtl/pcls_chk.sv =====
// Port-level checker for the point centroid and sort block, with its bind.
module pcls_chk
  import pcls_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_point,
  input logic out_valid,
  input logic out_result_kind,
  input logic out_last_result
);

  // A word that does not close the set leaves the block ready.
  a_mid_ready: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_point |=> !busy)
    else $error("block went busy after a non-final point");

  // The closing word always starts the computation.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_point |=> busy)
    else $error("block stayed ready after the final point");

  // Only a sorted point can end a run.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |-> out_result_kind == KIND_POINT)
    else $error("final flag on a centroid word");

  // The only word seen while ready is the one that ends the run.
  a_idle_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy |-> out_last_result)
    else $error("result strobe while ready that does not end the run");

  // No result strobe follows right after the closing point; the centroid word comes later.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_point |=> !out_valid)
    else $error("result strobe right after the final point");

endmodule

bind point_centroid_and_lex_sort pcls_chk u_pcls_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_last_point   (in_last_point),
  .out_valid       (out_valid),
  .out_result_kind (out_result_kind),
  .out_last_result (out_last_result)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the point centroid and lexicographic sort block.
`timescale 1ns / 1ps

module tb_top;
  import pcls_pkg::*;

  localparam int MAX_POINTS = 32;
  localparam int COORD_BITS = 16;
  localparam int RANDOM_WORDS = 204;
  localparam int TAIL_CYCLES = 200;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OUT_W-1:0] wide_t;

  typedef struct packed {
    logic  kind;
    wide_t x;
    wide_t y;
    logic  last;
  } result_t;

  // One directed word; a set of one point has its centroid written out by hand.
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
    logic   typed;
    wide_t  cx;
    wide_t  cy;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 16;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   start;
  logic   busy;
  coord_t in_point_x;
  coord_t in_point_y;
  logic   in_last_point;
  logic   out_valid;
  logic   out_result_kind;
  wide_t  out_x;
  wide_t  out_y;
  logic   out_last_result;

  // Points of the set being loaded, with their running sums.
  coord_t  set_x [MAX_POINTS];
  coord_t  set_y [MAX_POINTS];
  int      set_count;
  longint  set_sum_x;
  longint  set_sum_y;
  result_t expected_results [$];
  result_t next_result;
  int      mismatches;
  bit      no_gaps;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{32767, -32768, 1'b1, 1'b1, 8388352, -8388608},
    '{-32768, 32767, 1'b1, 1'b1, -8388608, 8388352},
    '{0, 0, 1'b1, 1'b1, 0, 0},
    '{5, 7, 1'b0, 1'b0, 0, 0},
    '{5, -3, 1'b0, 1'b0, 0, 0},
    '{-2, 100, 1'b1, 1'b0, 0, 0},
    '{-1, -1, 1'b0, 1'b0, 0, 0},
    '{0, 0, 1'b0, 1'b0, 0, 0},
    '{0, 0, 1'b1, 1'b0, 0, 0},
    '{3, 3, 1'b0, 1'b0, 0, 0},
    '{3, 3, 1'b0, 1'b0, 0, 0},
    '{3, 3, 1'b1, 1'b0, 0, 0},
    '{10, 0, 1'b0, 1'b0, 0, 0},
    '{9, 5, 1'b0, 1'b0, 0, 0},
    '{9, -5, 1'b0, 1'b0, 0, 0},
    '{-10, 0, 1'b1, 1'b0, 0, 0}
  };

  point_centroid_and_lex_sort #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_last_point  (in_last_point),
    .out_valid      (out_valid),
    .out_result_kind(out_result_kind),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_last_result(out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Adds one accepted point to the set; a last point queues the centroid and the
  // sorted points, then empties the set.
  task automatic fold_point_into_set(input coord_t x, input coord_t y, input logic last,
                                     input logic typed, input wide_t typed_cx,
                                     input wide_t typed_cy);
    result_t r;
    coord_t  tx;
    coord_t  ty;
    longint  cx;
    longint  cy;
    int      j;
    if (set_count < MAX_POINTS) begin
      set_x[set_count] = x;
      set_y[set_count] = y;
      set_count++;
      set_sum_x += x;
      set_sum_y += y;
    end
    if (last) begin
      cx = (set_sum_x * 256) / set_count;
      cy = (set_sum_y * 256) / set_count;
      r.kind = KIND_CENTROID;
      r.x = typed ? typed_cx : cx[OUT_W-1:0];
      r.y = typed ? typed_cy : cy[OUT_W-1:0];
      r.last = 1'b0;
      expected_results.push_back(r);
      for (int i = 1; i < set_count; i++) begin
        j = i;
        while (j > 0 && (set_x[j-1] > set_x[j] ||
                         (set_x[j-1] == set_x[j] && set_y[j-1] > set_y[j]))) begin
          tx = set_x[j];
          ty = set_y[j];
          set_x[j] = set_x[j-1];
          set_y[j] = set_y[j-1];
          set_x[j-1] = tx;
          set_y[j-1] = ty;
          j--;
        end
      end
      for (int k = 0; k < set_count; k++) begin
        r.kind = KIND_POINT;
        r.x = OUT_W'(set_x[k]);
        r.y = OUT_W'(set_y[k]);
        r.last = (k == set_count - 1);
        expected_results.push_back(r);
      end
      set_count = 0;
      set_sum_x = 0;
      set_sum_y = 0;
    end
  endtask

  // Offers one word and returns at the edge that accepts it.
  task automatic send_word(input coord_t x, input coord_t y, input logic last,
                           input logic typed, input wide_t typed_cx, input wide_t typed_cy);
    start <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_last_point <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    fold_point_into_set(x, y, last, typed, typed_cx, typed_cy);
  endtask

  task automatic idle_gap();
    int roll;
    int gap;
    roll = $urandom_range(99);
    gap = 0;
    if (no_gaps || roll < 65) gap = 0;
    else if (roll < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Always lets at least one edge pass, so start is never assigned twice in a step.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic coord_t pick_coord();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) begin
      case ($urandom_range(3))
        0: return coord_t'(-32768);
        1: return coord_t'(32767);
        2: return coord_t'(0);
        default: return coord_t'(-1);
      endcase
    end
    // A narrow range makes equal x values, and whole equal points, common.
    if (roll < 40) return coord_t'(int'($urandom_range(6)) - 3);
    return coord_t'($urandom());
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: kind %0b x %0d y %0d last %0b",
               out_result_kind, out_x, out_y, out_last_result);
        mismatches++;
      end else begin
        next_result = expected_results.pop_front();
        if (out_result_kind !== next_result.kind) begin
          $error("result_kind: expected %0b, got %0b", next_result.kind, out_result_kind);
          mismatches++;
        end
        if (out_x !== next_result.x) begin
          $error("out_x: expected %0d, got %0d", next_result.x, out_x);
          mismatches++;
        end
        if (out_y !== next_result.y) begin
          $error("out_y: expected %0d, got %0d", next_result.y, out_y);
          mismatches++;
        end
        if (out_last_result !== next_result.last) begin
          $error("last_result: expected %0b, got %0b", next_result.last, out_last_result);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int     words_sent;
    int     set_size;
    int     set_index;
    coord_t x;
    coord_t y;
    rst_n = 1'b0;
    start = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_last_point = 1'b0;
    set_count = 0;
    set_sum_x = 0;
    set_sum_y = 0;
    mismatches = 0;
    no_gaps = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes, ties on x, truncation toward zero, equal points.
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].cx, directed_rows[i].cy);
      idle_gap();
    end
    drain_results();

    // Random sets; the first one overflows the point store.
    words_sent = 0;
    set_index = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (set_index == 0) set_size = MAX_POINTS + 2;
      else if ($urandom_range(7) == 0) set_size = $urandom_range(MAX_POINTS - 2, MAX_POINTS + 4);
      else set_size = $urandom_range(1, 8);
      no_gaps = ($urandom_range(3) == 0);
      for (int p = 0; p < set_size; p++) begin
        x = pick_coord();
        y = pick_coord();
        send_word(x, y, p == set_size - 1, 1'b0, '0, '0);
        words_sent++;
        if (p != set_size - 1) idle_gap();
      end
      if ($urandom_range(5) == 0) drain_results();
      else idle_gap();
      set_index++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("point_centroid_and_lex_sort verification clean");
    end else begin
      $display("point_centroid_and_lex_sort verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("point_centroid_and_lex_sort verification failed");
    $finish;
  end

endmodule
